[rtl/kee_pkg.sv]
// Shared types, constants and the sine table builder for the keyframe easing envelope.
// Depends on nothing; every other file of the block but kee_ram imports it.
package kee_pkg;

	localparam int SEGMENTS_DEF  = 8;
	localparam int SINE_BITS_DEF = 8;

	localparam int LEN_W   = 24;
	localparam int DT_W    = 16;
	localparam int SLOT_W  = 3;
	localparam int PH_W    = 17;
	localparam int VAL_W   = 16;
	localparam int CNT_W   = 4;
	localparam int CIDX_W  = 3;
	localparam int DIV_W   = 41;
	localparam int DVS_W   = 24;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_SETPOS = 2'd2;

	localparam logic [1:0] CURVE_NONE   = 2'd0;
	localparam logic [1:0] CURVE_LINEAR = 2'd1;
	localparam logic [1:0] CURVE_IN     = 2'd2;
	localparam logic [1:0] CURVE_OUT    = 2'd3;

	localparam logic [CIDX_W-1:0] REG_LENGTH  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_PLAY    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_REPEAT  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_REVERSE = 3'd3;
	localparam logic [CIDX_W-1:0] REG_COUNT   = 3'd4;

	localparam logic [PH_W-1:0] ONE_Q16 = 17'd65536;

	typedef struct packed {
		logic [1:0]              action;
		logic [DT_W-1:0]         delta_time;
		logic [SLOT_W-1:0]       seg_slot;
		logic [PH_W-1:0]         phase_start;
		logic [PH_W-1:0]         phase_end;
		logic signed [VAL_W-1:0] value_start;
		logic signed [VAL_W-1:0] value_end;
		logic [1:0]              curve;
		logic [LEN_W-1:0]        new_position;
	} item_t;

	typedef struct packed {
		logic [PH_W-1:0]         phase_start;
		logic [PH_W-1:0]         phase_end;
		logic signed [VAL_W-1:0] value_start;
		logic signed [VAL_W-1:0] value_end;
		logic [1:0]              curve;
	} entry_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             play;
		logic             rpt;
		logic             rev;
		logic [2:0]       last;
	} cfg_t;

	// sin(i/2^bits * 90 deg) in Q1.16 from an eight-term Taylor series in Q30
	function automatic logic [PH_W-1:0] sine_entry(int unsigned i, int unsigned bits);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		longint      e;
		int          k;
		x = (64'd1686629713 * 64'(i)) >> bits;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 7; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if ((k & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		e = (sum + 64'sd8192) >>> 14;
		if (e > 65536) begin
			e = 65536;
		end
		return PH_W'(e);
	endfunction

endpackage

[rtl/kee_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/kee_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on kee_pkg for the operand widths.
module kee_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kee_pkg::DIV_W-1:0]  dividend,
	input  logic [kee_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [kee_pkg::DIV_W-1:0]  quotient,
	output logic [kee_pkg::DVS_W-1:0]  remainder
);
	import kee_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   r2;
	logic             ge;

	assign r2 = {rem_q, dvd_q[DIV_W-1]};
	assign ge = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? DVS_W'(r2 - {1'b0, dvs_q}) : DVS_W'(r2);
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;
endmodule

[rtl/kee_front.sv]
// Front end: takes input items, drops unused actions and queues the rest for the back end.
// Depends on kee_pkg for the item type and action codes.
module kee_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  kee_pkg::item_t in_item,
	output logic           q_valid,
	output kee_pkg::item_t q_item,
	input  logic           q_take
);
	import kee_pkg::*;

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       accept;

	assign full    = cnt_q == 2'd2;
	assign accept  = push && !full;
	assign keep    = accept && (in_item.action == ACT_TICK || in_item.action == ACT_WRITE ||
		in_item.action == ACT_SETPOS);
	assign q_valid = cnt_q != 2'd0;
	assign q_item  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) begin
				wr_q <= !wr_q;
			end
			if (q_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, q_take};
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			buf_q[wr_q] <= in_item;
		end
	end
endmodule

[rtl/kee_back.sv]
// Back end: sequencer that executes queued items, holds the segment RAM, the divider
// and the sine table, and drives the result register. Depends on kee_pkg, kee_ram, kee_div.
module kee_back #(
	parameter int SEGMENTS        = kee_pkg::SEGMENTS_DEF,
	parameter int SINE_TABLE_BITS = kee_pkg::SINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kee_pkg::cfg_t                     cfg,
	input  logic                              q_valid,
	input  kee_pkg::item_t                    q_item,
	output logic                              q_take,
	input  logic                              out_pop,
	output logic                              out_valid,
	output logic signed [kee_pkg::VAL_W-1:0]  tween_value,
	output logic [kee_pkg::LEN_W-1:0]         play_position,
	output logic [2:0]                        active_segment,
	output logic                              at_end
);
	import kee_pkg::*;

	localparam int AW = SEGMENTS > 1 ? $clog2(SEGMENTS) : 1;
	localparam int N  = 1 << SINE_TABLE_BITS;
	localparam int TW = SINE_TABLE_BITS + 1;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_ADJ  = 4'd1;
	localparam logic [3:0] B_MOD  = 4'd2;
	localparam logic [3:0] B_PH   = 4'd3;
	localparam logic [3:0] B_RD   = 4'd4;
	localparam logic [3:0] B_CHK  = 4'd5;
	localparam logic [3:0] B_F    = 4'd6;
	localparam logic [3:0] B_FDIV = 4'd7;
	localparam logic [3:0] B_W    = 4'd8;
	localparam logic [3:0] B_TA   = 4'd9;
	localparam logic [3:0] B_TB   = 4'd10;
	localparam logic [3:0] B_IP   = 4'd11;
	localparam logic [3:0] B_IS   = 4'd12;
	localparam logic [3:0] B_MUL  = 4'd13;
	localparam logic [3:0] B_SUM  = 4'd14;
	localparam logic [3:0] B_DONE = 4'd15;

	logic [3:0]              st_q, st_n;
	logic signed [25:0]      p_q, p_n;
	logic [2:0]              seg_q, seg_n;
	logic [PH_W-1:0]         phase_q, phase_n;
	entry_t                  ent_q, ent_n;
	logic [PH_W-1:0]         f_q, f_n;
	logic [PH_W-1:0]         x_q, x_n;
	logic [PH_W-1:0]         a_q, b_q;
	logic [PH_W-1:0]         ip_q;
	logic [PH_W-1:0]         w_q, w_n;
	logic signed [34:0]      mul_q;
	logic signed [VAL_W-1:0] val_q, val_n;
	logic [LEN_W-1:0]        pos_now_q, pos_now_n;
	logic [2:0]              seg_now_q, seg_now_n;
	logic                    out_valid_q;
	logic                    load;

	logic                    div_start;
	logic [DIV_W-1:0]        div_dividend;
	logic [DVS_W-1:0]        div_divisor;
	logic                    div_done;
	logic [DIV_W-1:0]        div_quot;
	logic [DVS_W-1:0]        div_rem;

	logic                    ram_we;
	entry_t                  ram_wdata;
	entry_t                  ram_rdata;
	logic [PH_W-1:0]         sine_rom [N+1];

	logic signed [25:0]      len26;
	logic signed [25:0]      pos26;
	logic signed [25:0]      dt26;
	logic signed [17:0]      span;
	logic signed [17:0]      rel;
	logic [TW-1:0]           idx;
	logic [TW-1:0]           idx_a;
	logic [TW-1:0]           idx_b;
	logic [15:0]             frac;
	logic [PH_W-1:0]         sine_sum;
	logic signed [16:0]      dv;
	logic signed [18:0]      scaled;
	logic signed [19:0]      vsum;

	for (genvar gi = 0; gi <= N; gi++) begin : g_rom
		assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
	end

	kee_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(q_item.seg_slot)),
		.wdata (ram_wdata),
		.raddr (AW'(seg_q)),
		.rdata (ram_rdata)
	);

	kee_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign len26  = $signed({2'b00, cfg.length});
	assign pos26  = $signed({2'b00, pos_now_q});
	assign dt26   = $signed({10'd0, q_item.delta_time});
	assign q_take = (st_q == B_IDLE) && q_valid;
	assign ram_we = q_take && q_item.action == ACT_WRITE &&
		32'(q_item.seg_slot) < SEGMENTS;
	assign ram_wdata = '{phase_start: q_item.phase_start, phase_end: q_item.phase_end,
		value_start: q_item.value_start, value_end: q_item.value_end, curve: q_item.curve};

	assign span  = $signed({1'b0, ent_q.phase_end}) - $signed({1'b0, ent_q.phase_start});
	assign rel   = $signed({1'b0, phase_q}) - $signed({1'b0, ent_q.phase_start});
	assign idx   = x_q[PH_W-1 -: TW];
	assign idx_a = (idx >= TW'(N)) ? TW'(N) : idx;
	assign idx_b = (idx >= TW'(N)) ? TW'(N) : idx + 1'b1;
	assign frac  = 16'(32'(x_q) << SINE_TABLE_BITS);
	assign sine_sum = (b_q < a_q) ? a_q : a_q + ip_q;
	assign dv     = 17'(ent_q.value_end) - 17'(ent_q.value_start);
	assign scaled = 19'(mul_q >>> 16);
	assign vsum   = 20'(scaled) + 20'(ent_q.value_start);
	assign load   = (st_q == B_DONE) && (!out_valid_q || out_pop);

	always_comb begin
		st_n         = st_q;
		p_n          = p_q;
		seg_n        = seg_q;
		phase_n      = phase_q;
		ent_n        = ent_q;
		f_n          = f_q;
		x_n          = x_q;
		w_n          = w_q;
		val_n        = val_q;
		pos_now_n    = pos_now_q;
		seg_now_n    = seg_now_q;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = cfg.length;
		unique case (st_q)
			B_IDLE: begin
				if (q_take) begin
					unique case (q_item.action)
						ACT_SETPOS: begin
							pos_now_n = (q_item.new_position > cfg.length) ? cfg.length :
								q_item.new_position;
							seg_now_n = cfg.rev ? cfg.last : 3'd0;
						end
						ACT_TICK: begin
							p_n = !cfg.play ? pos26 : (cfg.rev ? pos26 - dt26 : pos26 + dt26);
							seg_n = (seg_now_q > cfg.last) ? cfg.last : seg_now_q;
							st_n = B_ADJ;
						end
						default: begin
						end
					endcase
				end
			end
			B_ADJ: begin
				div_start = 1'b1;
				priority if (!cfg.rev && p_q > len26) begin
					if (cfg.rpt) begin
						div_dividend = DIV_W'(p_q - 26'sd1);
						seg_n = 3'd0;
						st_n = B_MOD;
					end else begin
						p_n = len26;
						seg_n = cfg.last;
						div_dividend = DIV_W'({cfg.length, 16'h0000});
						st_n = B_PH;
					end
				end else if (cfg.rev && p_q < 0) begin
					if (cfg.rpt) begin
						div_dividend = DIV_W'(-p_q - 26'sd1);
						seg_n = cfg.last;
						st_n = B_MOD;
					end else begin
						p_n = '0;
						seg_n = 3'd0;
						div_dividend = '0;
						st_n = B_PH;
					end
				end else begin
					div_dividend = DIV_W'({p_q[LEN_W-1:0], 16'h0000});
					st_n = B_PH;
				end
			end
			B_MOD: begin
				if (div_done) begin
					p_n = !cfg.rev ? $signed({2'b00, div_rem}) + 26'sd1 :
						len26 - $signed({2'b00, div_rem}) - 26'sd1;
					div_start = 1'b1;
					div_dividend = DIV_W'({p_n[LEN_W-1:0], 16'h0000});
					st_n = B_PH;
				end
			end
			B_PH: begin
				if (div_done) begin
					phase_n = (div_quot > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_quot[PH_W-1:0];
					st_n = B_RD;
				end
			end
			B_RD: begin
				st_n = B_CHK;
			end
			B_CHK: begin
				// advance the search one segment per RAM read
				if (!cfg.rev && p_q < len26 && seg_q < cfg.last &&
						phase_q > ram_rdata.phase_end) begin
					seg_n = seg_q + 1'b1;
					st_n = B_RD;
				end else if (cfg.rev && p_q > 0 && seg_q != 3'd0 &&
						phase_q < ram_rdata.phase_start) begin
					seg_n = seg_q - 1'b1;
					st_n = B_RD;
				end else begin
					ent_n = ram_rdata;
					st_n = B_F;
				end
			end
			B_F: begin
				if (ent_q.value_start == ent_q.value_end || ent_q.curve == CURVE_NONE) begin
					val_n = ent_q.value_start;
					st_n = B_DONE;
				end else if (span > 0 && rel > 0) begin
					div_start = 1'b1;
					div_dividend = DIV_W'({rel[PH_W-1:0], 16'h0000});
					div_divisor = DVS_W'(span[PH_W-1:0]);
					st_n = B_FDIV;
				end else begin
					f_n = '0;
					st_n = B_W;
				end
			end
			B_FDIV: begin
				if (div_done) begin
					f_n = (div_quot > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_quot[PH_W-1:0];
					st_n = B_W;
				end
			end
			B_W: begin
				if (ent_q.curve == CURVE_LINEAR) begin
					w_n = f_q;
					st_n = B_MUL;
				end else begin
					x_n = (ent_q.curve == CURVE_IN) ? ONE_Q16 - f_q : f_q;
					st_n = B_TA;
				end
			end
			B_TA: st_n = B_TB;
			B_TB: st_n = B_IP;
			B_IP: st_n = B_IS;
			B_IS: begin
				w_n = (ent_q.curve == CURVE_IN) ? ONE_Q16 - sine_sum : sine_sum;
				st_n = B_MUL;
			end
			B_MUL: st_n = B_SUM;
			B_SUM: begin
				priority if (vsum > 20'sd32767) begin
					val_n = 16'sh7FFF;
				end else if (vsum < -20'sd32768) begin
					val_n = -16'sh8000;
				end else begin
					val_n = vsum[VAL_W-1:0];
				end
				st_n = B_DONE;
			end
			B_DONE: begin
				// hold until the result register is free
				if (load) begin
					pos_now_n = p_q[LEN_W-1:0];
					seg_now_n = seg_q;
					st_n = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			pos_now_q   <= '0;
			seg_now_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q      <= st_n;
			pos_now_q <= pos_now_n;
			seg_now_q <= seg_now_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q     <= p_n;
		seg_q   <= seg_n;
		phase_q <= phase_n;
		ent_q   <= ent_n;
		f_q     <= f_n;
		x_q     <= x_n;
		w_q     <= w_n;
		val_q   <= val_n;
		if (st_q == B_TA) begin
			a_q <= sine_rom[idx_a];
		end
		if (st_q == B_TB) begin
			b_q <= sine_rom[idx_b];
		end
		ip_q  <= PH_W'((33'(b_q - a_q) * 33'(frac)) >> 16);
		mul_q <= 35'($signed({1'b0, w_q}) * 35'(dv));
		if (load) begin
			tween_value    <= val_q;
			play_position  <= p_q[LEN_W-1:0];
			active_segment <= seg_q;
			at_end         <= !cfg.rpt && ((!cfg.rev && p_q >= len26) || (cfg.rev && p_q == 0));
		end
	end

	assign out_valid = out_valid_q;

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_CHK) |-> (seg_q <= cfg.last))
		else $error("segment search left the segments in use");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_DONE && out_valid_q && !out_pop) |=> (st_q == B_DONE && out_valid_q))
		else $error("finished tick did not wait for the result register");

	a_phase_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_RD) |-> (phase_q <= ONE_Q16))
		else $error("phase above one");

	a_position_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (p_q >= 0 && p_q <= len26))
		else $error("position outside the tween length");
endmodule

[rtl/keyframe_easing_envelope_core.sv]
// Keyframe easing envelope: up to SEGMENTS segments (at most 8), piecewise tween with sine easing.
// Depends on kee_pkg, kee_front, kee_back.
//
// Write the registers while idle, load segments with write-segment items, then send
// ticks; each tick gives one result, other actions give none. A segment write or a set
// position is handled while the back end stays idle. A tick uses the shared
// one-bit-per-cycle divider, which works out the phase always, the wrap remainder when
// the position wraps, and the fraction within the segment for linear and eased curves.
// A two-entry queue sits in front, so items keep arriving while a tick runs.
module keyframe_easing_envelope_core #(
	parameter int SEGMENTS        = kee_pkg::SEGMENTS_DEF,
	parameter int SINE_TABLE_BITS = kee_pkg::SINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [kee_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [kee_pkg::LEN_W-1:0]         cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        action,
	input  logic [kee_pkg::DT_W-1:0]          delta_time,
	input  logic [kee_pkg::SLOT_W-1:0]        seg_slot,
	input  logic [kee_pkg::PH_W-1:0]          seg_phase_start,
	input  logic [kee_pkg::PH_W-1:0]          seg_phase_end,
	input  logic signed [kee_pkg::VAL_W-1:0]  seg_value_start,
	input  logic signed [kee_pkg::VAL_W-1:0]  seg_value_end,
	input  logic [1:0]                        seg_curve,
	input  logic [kee_pkg::LEN_W-1:0]         new_position,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [kee_pkg::VAL_W-1:0]  tween_value,
	output logic [kee_pkg::LEN_W-1:0]         play_position,
	output logic [2:0]                        active_segment,
	output logic                              at_end
);
	import kee_pkg::*;

	localparam int SEG_CAP = SEGMENTS < 8 ? SEGMENTS : 8;

	logic [LEN_W-1:0] len_q;
	logic             play_q;
	logic             rpt_q;
	logic             rev_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_eff;
	cfg_t             cfg;
	item_t            in_item;
	item_t            q_item;
	logic             q_valid;
	logic             q_take;
	logic             out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 24'd65536;
			play_q <= 1'b0;
			rpt_q  <= 1'b0;
			rev_q  <= 1'b0;
			cnt_q  <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LENGTH:  len_q  <= cfg_data;
				REG_PLAY:    play_q <= cfg_data[0];
				REG_REPEAT:  rpt_q  <= cfg_data[0];
				REG_REVERSE: rev_q  <= cfg_data[0];
				REG_COUNT:   cnt_q  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero length acts as one, segment count clamps into range
	assign cnt_eff = (cnt_q == '0) ? CNT_W'(1) :
		((32'(cnt_q) > SEG_CAP) ? CNT_W'(SEG_CAP) : cnt_q);
	assign cfg.length = (len_q == '0) ? LEN_W'(1) : len_q;
	assign cfg.play   = play_q;
	assign cfg.rpt    = rpt_q;
	assign cfg.rev    = rev_q;
	assign cfg.last   = 3'(cnt_eff - 1'b1);

	assign in_item = '{action: action, delta_time: delta_time, seg_slot: seg_slot,
		phase_start: seg_phase_start, phase_end: seg_phase_end,
		value_start: seg_value_start, value_end: seg_value_end,
		curve: seg_curve, new_position: new_position};

	kee_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	kee_back #(
		.SEGMENTS        (SEGMENTS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_take         (q_take),
		.out_pop        (pop),
		.out_valid      (out_valid),
		.tween_value    (tween_value),
		.play_position  (play_position),
		.active_segment (active_segment),
		.at_end         (at_end)
	);

	assign empty = !out_valid;
endmodule

[tb/sv/keyframe_easing_envelope_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for keyframe_easing_envelope_core: directed table, then random
// phases under varied register settings, checked against an in-bench tween predictor.
// Depends on kee_pkg and the keyframe_easing_envelope_core RTL.
module keyframe_easing_envelope_core_tb;
	import kee_pkg::*;

	localparam int TABLE_N     = 256;
	localparam int IDLE_CYCLES = 400;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0]        pos;
		logic [2:0]              seg;
		logic                    endflag;
	} tween_out_t;

	typedef struct {
		item_t      it;
		bit         typed;
		tween_out_t res;
	} row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CIDX_W-1:0]       cfg_index;
	logic [LEN_W-1:0]        cfg_data;
	logic                    push;
	logic                    full;
	logic [1:0]              action;
	logic [DT_W-1:0]         delta_time;
	logic [SLOT_W-1:0]       seg_slot;
	logic [PH_W-1:0]         seg_phase_start;
	logic [PH_W-1:0]         seg_phase_end;
	logic signed [VAL_W-1:0] seg_value_start;
	logic signed [VAL_W-1:0] seg_value_end;
	logic [1:0]              seg_curve;
	logic [LEN_W-1:0]        new_position;
	logic                    empty;
	logic                    pop;
	logic signed [VAL_W-1:0] tween_value;
	logic [LEN_W-1:0]        play_position;
	logic [2:0]              active_segment;
	logic                    at_end;

	keyframe_easing_envelope_core dut (.*);

	// predictor state
	longint     sine_q16 [0:TABLE_N];
	longint     m_len, m_play, m_rpt, m_rev, m_count;
	longint     m_pos, m_seg;
	longint     m_lo [8], m_hi [8], m_vs [8], m_ve [8], m_kind [8];
	tween_out_t tween_q [$];
	int         errors;
	int         burst_left;
	longint     cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyframe_easing_envelope_core verification failed");
			$finish;
		end
	end

	function automatic void build_sine_q16();
		longint unsigned x, term;
		longint          acc, e;
		for (int i = 0; i <= TABLE_N; i++) begin
			x = 64'd1686629713 * longint'(i) / TABLE_N;
			term = x;
			acc = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / longint'((2 * k) * (2 * k + 1));
				acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			e = (acc + 8192) >>> 14;
			sine_q16[i] = (e > 65536) ? 65536 : e;
		end
	endfunction

	function automatic longint quarter_sine(longint f);
		longint p, idx, frac, a, b;
		p = f * TABLE_N;
		idx = p >>> 16;
		frac = p & 16'hFFFF;
		if (idx >= TABLE_N) return sine_q16[TABLE_N];
		a = sine_q16[idx];
		b = sine_q16[idx + 1];
		if (b < a) return a;
		return a + (((b - a) * frac) >>> 16);
	endfunction

	function automatic longint eased_value(longint s, longint phase);
		longint span, rel, f, w, v;
		f = 0;
		if (m_vs[s] == m_ve[s] || m_kind[s] == CURVE_NONE) return m_vs[s];
		span = m_hi[s] - m_lo[s];
		rel = phase - m_lo[s];
		if (span > 0 && rel > 0) begin
			f = rel * 65536 / span;
			if (f > 65536) f = 65536;
		end
		case (m_kind[s])
			CURVE_LINEAR: w = f;
			CURVE_IN:     w = 65536 - quarter_sine(65536 - f);
			default:      w = quarter_sine(f);
		endcase
		v = m_vs[s] + ((w * (m_ve[s] - m_vs[s])) >>> 16);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// advance the tween model by one accepted item; returns 1 when a result is due
	function automatic bit advance_tween(item_t it, output tween_out_t r);
		longint len, last, p, s, phase;
		len = (m_len == 0) ? 1 : m_len;
		last = (m_count < 1) ? 0 : ((m_count > 8) ? 7 : m_count - 1);
		case (it.action)
			ACT_WRITE: begin
				m_lo[it.seg_slot] = it.phase_start;
				m_hi[it.seg_slot] = it.phase_end;
				m_vs[it.seg_slot] = it.value_start;
				m_ve[it.seg_slot] = it.value_end;
				m_kind[it.seg_slot] = it.curve;
				return 0;
			end
			ACT_SETPOS: begin
				m_pos = (it.new_position > len) ? len : it.new_position;
				m_seg = m_rev ? last : 0;
				return 0;
			end
			ACT_TICK: ;
			default: return 0;
		endcase
		p = m_pos;
		s = (m_seg > last) ? last : m_seg;
		if (m_play) p = m_rev ? p - it.delta_time : p + it.delta_time;
		if (!m_rev && p > len) begin
			if (m_rpt) begin
				p = (p - 1) % len + 1;
				s = 0;
			end else begin
				p = len;
				s = last;
			end
		end
		if (m_rev && p < 0) begin
			if (m_rpt) begin
				p = len - ((-p - 1) % len) - 1;
				s = last;
			end else begin
				p = 0;
				s = 0;
			end
		end
		phase = p * 65536 / len;
		if (phase > 65536) phase = 65536;
		if (!m_rev) begin
			while (p < len && s < last && phase > m_hi[s]) s++;
		end else begin
			while (p > 0 && s > 0 && phase < m_lo[s]) s--;
		end
		m_pos = p;
		m_seg = s;
		r.value = VAL_W'(eased_value(s, phase));
		r.pos = LEN_W'(p);
		r.seg = 3'(s);
		r.endflag = !m_rpt && ((!m_rev && p >= len) || (m_rev && p == 0));
		return 1;
	endfunction

	function automatic item_t seg_item(int slot, int ps, int pe, int vs, int ve, int kind);
		item_t it;
		it = '0;
		it.action = ACT_WRITE;
		it.seg_slot = 3'(slot);
		it.phase_start = PH_W'(ps);
		it.phase_end = PH_W'(pe);
		it.value_start = VAL_W'(vs);
		it.value_end = VAL_W'(ve);
		it.curve = 2'(kind);
		return it;
	endfunction

	function automatic item_t tick_item(int dt);
		item_t it;
		it = '0;
		it.action = ACT_TICK;
		it.delta_time = DT_W'(dt);
		return it;
	endfunction

	function automatic item_t setpos_item(int np);
		item_t it;
		it = '0;
		it.action = ACT_SETPOS;
		it.new_position = LEN_W'(np);
		return it;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// offer one item, hold it until transferred, then update the model
	task automatic send(item_t it, bit typed = 0, tween_out_t given = '{0, 0, 0, 0});
		tween_out_t r;
		int         gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		push <= 1'b1;
		action <= it.action;
		delta_time <= it.delta_time;
		seg_slot <= it.seg_slot;
		seg_phase_start <= it.phase_start;
		seg_phase_end <= it.phase_end;
		seg_value_start <= it.value_start;
		seg_value_end <= it.value_end;
		seg_curve <= it.curve;
		new_position <= it.new_position;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		if (advance_tween(it, r)) tween_q.push_back(typed ? given : r);
		@(negedge clk);
	endtask

	// hold the sender until all results are in and the back end has drained
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (tween_q.size() != 0) @(negedge clk);
		repeat (IDLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_regs(int len, int play, int rpt, int rev, int cnt);
		int vals [5];
		vals = '{len, play, rpt, rev, cnt};
		foreach (vals[i]) begin
			cfg_write <= 1'b1;
			cfg_index <= CIDX_W'(i);
			cfg_data <= LEN_W'(vals[i]);
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		m_len = len & 24'hFFFFFF;
		m_play = play & 1;
		m_rpt = rpt & 1;
		m_rev = rev & 1;
		m_count = cnt & 4'hF;
	endtask

	// receiver: stall on a pattern that is picked at random from four modes and changes over the run
	int          pop_mode;
	int unsigned pop_ctr;
	always @(negedge clk) begin
		pop_ctr <= pop_ctr + 1;
		if (pop_ctr % 64 == 0) pop_mode <= $urandom_range(0, 3);
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) == 1);
			2: pop <= (pop_ctr % 16) < 3;
			default: pop <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		tween_out_t w;
		if (arst_n && pop && !empty) begin
			if (tween_q.size() == 0) begin
				report("result with nothing outstanding", 1, 0);
			end else begin
				w = tween_q.pop_front();
				if (tween_value !== w.value) report("tween_value", tween_value, w.value);
				if (play_position !== w.pos) report("play_position", play_position, w.pos);
				if (active_segment !== w.seg) report("active_segment", active_segment, w.seg);
				if (at_end !== w.endflag) report("at_end", at_end, w.endflag);
			end
		end
	end

	task automatic load_random_segments();
		int b [9];
		b[0] = 0;
		b[8] = 65536;
		for (int i = 1; i < 8; i++) begin
			b[i] = b[i - 1] + $urandom_range(0, (65536 - b[i - 1]) / (9 - i) * 2);
			if (b[i] > 65536) b[i] = 65536;
		end
		for (int i = 0; i < 8; i++) begin
			send(seg_item(i, b[i], b[i + 1], $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 3)));
		end
	endtask

	row_t       rows [$];
	tween_out_t exp_r;
	int         lens [8];
	int         len, dt_top, roll;

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		action = ACT_TICK;
		delta_time = '0;
		seg_slot = '0;
		seg_phase_start = '0;
		seg_phase_end = '0;
		seg_value_start = '0;
		seg_value_end = '0;
		seg_curve = CURVE_NONE;
		new_position = '0;
		pop = 1'b0;
		pop_mode = 0;
		pop_ctr = 0;
		cycles = 0;
		errors = 0;
		burst_left = 0;
		build_sine_q16();
		m_len = 65536;
		m_play = 0;
		m_rpt = 0;
		m_rev = 0;
		m_count = 1;
		m_pos = 0;
		m_seg = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every curve, equal values, empty and inverted spans, extremes
		rows.push_back('{seg_item(0, 0, 8192, -32768, 32767, CURVE_NONE), 0, exp_r});
		rows.push_back('{seg_item(1, 8192, 16384, -32768, 32767, CURVE_LINEAR), 0, exp_r});
		rows.push_back('{seg_item(2, 16384, 24576, 32767, -32768, CURVE_IN), 0, exp_r});
		rows.push_back('{seg_item(3, 24576, 32768, -32768, 32767, CURVE_OUT), 0, exp_r});
		rows.push_back('{seg_item(4, 32768, 40960, 1234, 1234, CURVE_OUT), 0, exp_r});
		rows.push_back('{seg_item(5, 49152, 40960, -500, 700, CURVE_LINEAR), 0, exp_r});
		rows.push_back('{seg_item(6, 49152, 49152, 300, -300, CURVE_IN), 0, exp_r});
		rows.push_back('{seg_item(7, 49152, 65536, 32767, -32768, CURVE_OUT), 0, exp_r});
		rows.push_back('{tick_item(16'hFFFF), 1, '{-32768, 0, 0, 0}});
		rows.push_back('{setpos_item(24'hFFFFFF), 0, exp_r});
		rows.push_back('{tick_item(0), 1, '{-32768, 65536, 0, 1}});
		rows.push_back('{'{action: 2'd3, default: '0}, 0, exp_r});
		rows.push_back('{setpos_item(0), 0, exp_r});
		rows.push_back('{tick_item(1), 1, '{-32768, 0, 0, 0}});
		foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
		drain();

		write_regs(65536, 1, 0, 0, 8);
		send(setpos_item(0));
		for (int i = 0; i < 10; i++) send(tick_item(7000));
		drain();
		write_regs(65536, 1, 0, 1, 8);
		send(setpos_item(65536));
		for (int i = 0; i < 10; i++) send(tick_item(7000));
		drain();

		lens = '{1, 0, 16777215, 65536, 3, 100, 2000, 777};
		for (int ph = 0; ph < 26; ph++) begin
			if (ph < 8) len = lens[ph];
			else if ($urandom_range(0, 5) == 0) len = $urandom_range(0, 24'hFFFFFF);
			else len = $urandom_range(1, 70000);
			if (ph < 4) write_regs(len, 1, ph % 2, ph / 2, (ph == 1) ? 0 : 15);
			else write_regs(len, $urandom_range(0, 7) != 0, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 15));
			if (ph % 3 == 0) load_random_segments();
			send(setpos_item($urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
				: $urandom_range(0, (len == 0) ? 1 : len)));
			dt_top = (len < 21845) ? len * 3 : 65535;
			for (int i = 0; i < 50; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) send(tick_item($urandom_range(0, dt_top)));
				else if (roll < 84) send(tick_item(($urandom_range(0, 1) == 1) ? 16'hFFFF : 0));
				else if (roll < 90) send(setpos_item($urandom_range(0, 24'hFFFFFF)));
				else if (roll < 93) send('{action: 2'd3, delta_time: DT_W'($urandom),
					default: '0});
				else send(seg_item($urandom_range(0, 7), $urandom_range(0, 65536),
					$urandom_range(0, 65536), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 3)));
			end
			drain();
		end

		if (errors == 0) begin
			$display("keyframe_easing_envelope_core verification clean");
		end else begin
			$display("keyframe_easing_envelope_core verification failed");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (tween_q.size() > 0 && !arst_n) report("results outstanding in reset", tween_q.size(), 0);
	end

endmodule
